FILE: rtl/core/a64enc_pkg.sv
// ----------------------------------------------------------------------------
// a64enc_pkg
// Shared types, codes and range helpers for the AArch64 instruction encoder.
// ----------------------------------------------------------------------------
package a64enc_pkg;

  // Instruction forms selected by the command field
  typedef enum logic [4:0] {
    CMD_ADR       = 5'd0,
    CMD_ADRP      = 5'd1,
    CMD_BR        = 5'd2,
    CMD_BLR       = 5'd3,
    CMD_LDP_IDX   = 5'd4,
    CMD_LDP_OFF   = 5'd5,
    CMD_STP_IDX   = 5'd6,
    CMD_STP_OFF   = 5'd7,
    CMD_NOP       = 5'd8,
    CMD_RET       = 5'd9,
    CMD_MOV_REG   = 5'd10,
    CMD_ADD_REG   = 5'd11,
    CMD_CMP_REG   = 5'd12,
    CMD_MSR       = 5'd13,
    CMD_CCMP      = 5'd14,
    CMD_LDR_REG   = 5'd15,
    CMD_STR_REG   = 5'd16,
    CMD_ADD_IMM   = 5'd17,
    CMD_BL        = 5'd18,
    CMD_B         = 5'd19,
    CMD_BCOND     = 5'd20,
    CMD_CBZ       = 5'd21,
    CMD_CMP_IMM   = 5'd22,
    CMD_MOVZ      = 5'd23,
    CMD_STR_UIMM  = 5'd24,
    CMD_STRB_UIMM = 5'd25,
    CMD_SUB_IMM   = 5'd26,
    CMD_SUBS_IMM  = 5'd27,
    CMD_MOVK      = 5'd28,
    CMD_LDR_UIMM  = 5'd29,
    CMD_TBZ       = 5'd30,
    CMD_LDR_LIT   = 5'd31
  } command_e;

  // Branch authentication modes
  typedef enum logic [2:0] {
    PAC_OFF  = 3'd0,
    PAC_AA   = 3'd1,
    PAC_AAZ  = 3'd2,
    PAC_AB   = 3'd3,
    PAC_ABZ  = 3'd4
  } pac_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_ALIGN = 3'd2,
    ST_AUTH  = 3'd3,
    ST_SHIFT = 3'd4
  } status_e;

  // Fixed words
  localparam logic [31:0] NOP_WORD = 32'hD503201F;
  localparam logic [31:0] RET_WORD = 32'hD65F03C0;

  // Load/store pair opcode tops (bits 31:22)
  localparam logic [9:0] LDP_IDX_TOP = 10'h2A3;
  localparam logic [9:0] LDP_OFF_TOP = 10'h2A5;
  localparam logic [9:0] STP_IDX_TOP = 10'h2A2;
  localparam logic [9:0] STP_OFF_TOP = 10'h2A4;

  // One request beat
  typedef struct packed {
    command_e           command;
    logic [63:0]        pc;
    logic signed [63:0] imm;
    logic [4:0]         reg_d;
    logic [4:0]         reg_n;
    logic [4:0]         reg_m;
    logic [4:0]         reg_t2;
    logic               variant;
    pac_e               pac_mode;
    logic [3:0]         cond_code;
    logic [14:0]        aux_value;
  } req_t;

  // |d| < 2**k for a true signed 65-bit difference d
  function automatic logic dist_below(input logic [64:0] d, input int unsigned k);
    logic [64:0] hi;
    logic [64:0] lo_mask;
    hi      = d >> k;
    lo_mask = ~({65{1'b1}} << k);
    return (hi == '0) || ((hi == ({65{1'b1}} >> k)) && ((d & lo_mask) != '0));
  endfunction

  // v lies in [-2**k, 2**k) as a 64-bit two's complement value
  function automatic logic fits_signed(input logic [63:0] v, input int unsigned k);
    logic [63:0] hi;
    hi = v >> k;
    return (hi == '0) || (hi == ({64{1'b1}} >> k));
  endfunction

endpackage

FILE: rtl/core/a64enc_core.sv
// ----------------------------------------------------------------------------
// a64enc_core
// Field packing and per-form range, alignment and mode checks for one request.
// ----------------------------------------------------------------------------
module a64enc_core (
  input  a64enc_pkg::req_t    req_i,
  output logic [31:0]         word_o,
  output a64enc_pkg::status_e status_o
);

  logic [64:0] dist_full;
  logic [63:0] diff;
  logic [52:0] page_diff;
  logic [64:0] page_full;
  logic [63:0] imm_u;

  logic [31:0]         w;
  a64enc_pkg::status_e st;

  // br/blr authentication fields
  logic       pac_z, pac_a, pac_m;
  logic [4:0] pac_mod;
  // sub/subs/cmp immediate
  logic        sub_sh;
  logic [11:0] sub_imm12;
  // movz/movk shift
  logic [1:0]  move_hw;
  logic        move_bad;
  // unsigned offset load/store
  logic [9:0]  uimm_top;
  logic [11:0] uimm_off;
  logic        uimm_misal;
  logic [9:0]  pair_top;

  // PC-relative differences
  assign imm_u     = req_i.imm;
  assign dist_full = {1'b0, imm_u} - {1'b0, req_i.pc};
  assign diff      = dist_full[63:0];
  assign page_diff = {1'b0, imm_u[63:12]} - {1'b0, req_i.pc[63:12]};
  assign page_full = {{12{page_diff[52]}}, page_diff};

  // Authentication mode decode
  always_comb begin
    pac_z   = 1'b0;
    pac_a   = 1'b1;
    pac_m   = 1'b0;
    pac_mod = req_i.reg_m;
    case (req_i.pac_mode)
      a64enc_pkg::PAC_OFF: begin
        pac_a   = 1'b0;
        pac_mod = 5'd0;
      end
      a64enc_pkg::PAC_AA: pac_z = 1'b1;
      a64enc_pkg::PAC_AAZ: pac_mod = 5'd31;
      a64enc_pkg::PAC_AB: begin
        pac_z = 1'b1;
        pac_m = 1'b1;
      end
      a64enc_pkg::PAC_ABZ: begin
        pac_m   = 1'b1;
        pac_mod = 5'd31;
      end
      default: ;
    endcase
  end

  // Subtract immediate: direct, or shifted by 12 when a clean 4 KiB multiple
  always_comb begin
    sub_sh    = 1'b0;
    sub_imm12 = imm_u[11:0];
    if (imm_u[63:12] != '0 && imm_u[63:24] == '0 && imm_u[11:0] == '0) begin
      sub_sh    = 1'b1;
      sub_imm12 = imm_u[23:12];
    end
  end

  // Move wide shift to hw
  always_comb begin
    move_hw  = 2'd0;
    move_bad = 1'b0;
    if (req_i.aux_value == 15'd0) begin
      move_hw = 2'd0;
    end else if (req_i.aux_value == 15'd16) begin
      move_hw = 2'd1;
    end else if (req_i.aux_value == 15'd32 && !req_i.variant) begin
      move_hw = 2'd2;
    end else if (req_i.aux_value == 15'd48 && !req_i.variant) begin
      move_hw = 2'd3;
    end else begin
      move_bad = 1'b1;
    end
  end

  // Unsigned offset scaling: 4 bytes with variant, else 8
  always_comb begin
    if (req_i.variant) begin
      uimm_top   = 10'h2E4;
      uimm_off   = imm_u[13:2];
      uimm_misal = imm_u[1:0] != 2'b00;
    end else begin
      uimm_top   = 10'h3E4;
      uimm_off   = imm_u[14:3];
      uimm_misal = imm_u[2:0] != 3'b000;
    end
    if (req_i.command == a64enc_pkg::CMD_LDR_UIMM) begin
      uimm_top[0] = 1'b1;
    end
  end

  // Pair opcode select
  always_comb begin
    case (req_i.command)
      a64enc_pkg::CMD_LDP_IDX: pair_top = a64enc_pkg::LDP_IDX_TOP;
      a64enc_pkg::CMD_LDP_OFF: pair_top = a64enc_pkg::LDP_OFF_TOP;
      a64enc_pkg::CMD_STP_IDX: pair_top = a64enc_pkg::STP_IDX_TOP;
      default:                 pair_top = a64enc_pkg::STP_OFF_TOP;
    endcase
  end

  // Per-form encode and checks
  always_comb begin
    w  = '0;
    st = a64enc_pkg::ST_OK;
    case (req_i.command)
      a64enc_pkg::CMD_ADR: begin
        if (!a64enc_pkg::dist_below(dist_full, 20)) st = a64enc_pkg::ST_RANGE;
        w = {1'b0, diff[1:0], 5'h10, diff[20:2], req_i.reg_d};
      end
      a64enc_pkg::CMD_ADRP: begin
        if (imm_u[11:0] != '0) begin
          st = a64enc_pkg::ST_ALIGN;
        end else if (!a64enc_pkg::dist_below(page_full, 20)) begin
          st = a64enc_pkg::ST_RANGE;
        end
        w = {1'b1, page_diff[1:0], 5'h10, page_diff[20:2], req_i.reg_d};
      end
      a64enc_pkg::CMD_BR, a64enc_pkg::CMD_BLR: begin
        if (req_i.pac_mode != a64enc_pkg::PAC_OFF && req_i.pac_mode != a64enc_pkg::PAC_AA
            && req_i.pac_mode != a64enc_pkg::PAC_AAZ && req_i.pac_mode != a64enc_pkg::PAC_AB
            && req_i.pac_mode != a64enc_pkg::PAC_ABZ) begin
          st = a64enc_pkg::ST_AUTH;
        end
        w = {7'h6B, pac_z, 2'b00, req_i.command == a64enc_pkg::CMD_BLR, 9'h1F0,
             pac_a, pac_m, req_i.reg_n, pac_mod};
      end
      a64enc_pkg::CMD_LDP_IDX, a64enc_pkg::CMD_LDP_OFF,
      a64enc_pkg::CMD_STP_IDX, a64enc_pkg::CMD_STP_OFF: begin
        w = {pair_top, imm_u[9:3], req_i.reg_t2, req_i.reg_n, req_i.reg_d};
        // pre-index bit only for the indexed forms
        if (req_i.command == a64enc_pkg::CMD_LDP_IDX ||
            req_i.command == a64enc_pkg::CMD_STP_IDX) begin
          w[24] = w[24] | req_i.variant;
        end
      end
      a64enc_pkg::CMD_NOP: w = a64enc_pkg::NOP_WORD;
      a64enc_pkg::CMD_RET: w = a64enc_pkg::RET_WORD;
      a64enc_pkg::CMD_MOV_REG: begin
        w = {2'b10, 6'h2A, 3'b000, req_i.reg_m, imm_u[5:0], req_i.reg_n, req_i.reg_d};
      end
      a64enc_pkg::CMD_ADD_REG: begin
        if (imm_u[63:6] != '0) st = a64enc_pkg::ST_RANGE;
        w = {1'b1, req_i.variant, 6'h0B, 3'b000, req_i.reg_m, imm_u[5:0],
             req_i.reg_n, req_i.reg_d};
      end
      a64enc_pkg::CMD_CMP_REG: begin
        if (imm_u[63:6] != '0) st = a64enc_pkg::ST_RANGE;
        w = {8'hEB, 3'b000, req_i.reg_m, imm_u[5:0], req_i.reg_n, req_i.reg_d};
      end
      a64enc_pkg::CMD_MSR: begin
        w = {10'h354, req_i.variant, 1'b1, req_i.aux_value, req_i.reg_d};
      end
      a64enc_pkg::CMD_CCMP: begin
        w = {1'b1, 10'h3D2, req_i.reg_m, req_i.cond_code, 2'b00, req_i.reg_n,
             req_i.aux_value[4:0]};
      end
      a64enc_pkg::CMD_LDR_REG, a64enc_pkg::CMD_STR_REG: begin
        w = {(req_i.variant ? 2'b10 : 2'b11),
             (req_i.command == a64enc_pkg::CMD_LDR_REG ? 9'h1C3 : 9'h1C1),
             req_i.reg_m, 6'h1A, req_i.reg_n, req_i.reg_d};
      end
      a64enc_pkg::CMD_ADD_IMM: begin
        if (!a64enc_pkg::fits_signed(imm_u, 12)) st = a64enc_pkg::ST_RANGE;
        w = {8'h91, 2'b00, imm_u[11:0], req_i.reg_n, req_i.reg_d};
      end
      a64enc_pkg::CMD_BL: w = {6'h25, diff[27:2]};
      a64enc_pkg::CMD_B: begin
        if (diff[1:0] != 2'b00) st = a64enc_pkg::ST_ALIGN;
        w = {6'h05, diff[27:2]};
      end
      a64enc_pkg::CMD_BCOND: begin
        if (diff[1:0] != 2'b00) st = a64enc_pkg::ST_ALIGN;
        w = {8'h54, diff[20:2], 1'b0, req_i.cond_code};
      end
      a64enc_pkg::CMD_CBZ: begin
        if (diff[1:0] != 2'b00) begin
          st = a64enc_pkg::ST_ALIGN;
        end else if (!a64enc_pkg::fits_signed(diff, 20)) begin
          st = a64enc_pkg::ST_RANGE;
        end
        w = {7'h5A, req_i.variant, diff[20:2], req_i.reg_d};
      end
      a64enc_pkg::CMD_CMP_IMM, a64enc_pkg::CMD_SUB_IMM, a64enc_pkg::CMD_SUBS_IMM: begin
        if (imm_u[63:12] != '0 && !sub_sh) st = a64enc_pkg::ST_RANGE;
        w = {(req_i.command == a64enc_pkg::CMD_SUB_IMM ? 8'hD1 : 8'hF1), 1'b0, sub_sh,
             sub_imm12, req_i.reg_n,
             (req_i.command == a64enc_pkg::CMD_CMP_IMM ? 5'd31 : req_i.reg_d)};
      end
      a64enc_pkg::CMD_MOVZ, a64enc_pkg::CMD_MOVK: begin
        if (move_bad) st = a64enc_pkg::ST_SHIFT;
        w = {~req_i.variant, (req_i.command == a64enc_pkg::CMD_MOVZ ? 8'hA5 : 8'hE5),
             move_hw, imm_u[15:0], req_i.reg_d};
      end
      a64enc_pkg::CMD_STR_UIMM, a64enc_pkg::CMD_LDR_UIMM: begin
        if (uimm_misal) st = a64enc_pkg::ST_ALIGN;
        w = {uimm_top, uimm_off, req_i.reg_n, req_i.reg_d};
      end
      a64enc_pkg::CMD_STRB_UIMM: begin
        w = {10'h0E4, imm_u[11:0], req_i.reg_n, req_i.reg_d};
      end
      a64enc_pkg::CMD_TBZ: begin
        if (diff[1:0] != 2'b00) begin
          st = a64enc_pkg::ST_ALIGN;
        end else if (!a64enc_pkg::fits_signed(diff, 15)) begin
          st = a64enc_pkg::ST_RANGE;
        end
        w = {req_i.aux_value[5], 6'h1B, req_i.variant, req_i.aux_value[4:0],
             diff[15:2], req_i.reg_d};
      end
      a64enc_pkg::CMD_LDR_LIT: begin
        if (!a64enc_pkg::dist_below(dist_full, 18)) begin
          st = a64enc_pkg::ST_RANGE;
        end else if (diff[1:0] != 2'b00) begin
          st = a64enc_pkg::ST_ALIGN;
        end
        w = {8'h58, diff[20:2], req_i.reg_d};
      end
      default: begin
        w  = '0;
        st = a64enc_pkg::ST_OK;
      end
    endcase
  end

  // Word is cleared on any error
  assign word_o   = (st == a64enc_pkg::ST_OK) ? w : 32'd0;
  assign status_o = st;

endmodule

FILE: rtl/core/arm64_instruction_encoder.sv
// ----------------------------------------------------------------------------
// arm64_instruction_encoder
// Two-register pipeline around the AArch64 form encoder.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid_i / in_ready_o) carries one encode request
//   per beat: form, pc, immediate or target, registers, flags and operands.
//   The result channel (out_valid_o / out_ready_i) returns one beat per
//   request with the 32-bit machine word and a status; the word is zero
//   whenever the status is not ok.
//   An accepted request passes through the request register, then the
//   encode logic into the result register. Throughput is one request per
//   cycle while the receiver takes results, set by the single pass
//   through the encode logic between the two registers.
//   When the receiver stalls, the result register holds its beat and the
//   request register takes one more beat; in_ready_o then drops until the
//   result is taken. Requests and results keep their order.
//   Reset clears both valid flags; the block is ready right after reset.
// ----------------------------------------------------------------------------
module arm64_instruction_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         command_i,
  input  logic [63:0]        pc_i,
  input  logic signed [63:0] imm_i,
  input  logic [4:0]         reg_d_i,
  input  logic [4:0]         reg_n_i,
  input  logic [4:0]         reg_m_i,
  input  logic [4:0]         reg_t2_i,
  input  logic               variant_i,
  input  logic [2:0]         pac_mode_i,
  input  logic [3:0]         cond_code_i,
  input  logic [14:0]        aux_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        word_o,
  output logic [2:0]         status_o
);

  logic                req_valid_q, req_valid_d;
  a64enc_pkg::req_t    req_q, req_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         word_q;
  a64enc_pkg::status_e status_q;

  logic                in_fire;
  logic                req_adv;
  logic [31:0]         enc_word;
  a64enc_pkg::status_e enc_status;

  // Handshake control
  assign req_adv    = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || req_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    req_valid_d = req_valid_q;
    if (in_fire) begin
      req_valid_d = 1'b1;
    end else if (req_adv) begin
      req_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (req_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Request beat packing
  always_comb begin
    req_d.command   = a64enc_pkg::command_e'(command_i);
    req_d.pc        = pc_i;
    req_d.imm       = imm_i;
    req_d.reg_d     = reg_d_i;
    req_d.reg_n     = reg_n_i;
    req_d.reg_m     = reg_m_i;
    req_d.reg_t2    = reg_t2_i;
    req_d.variant   = variant_i;
    req_d.pac_mode  = a64enc_pkg::pac_e'(pac_mode_i);
    req_d.cond_code = cond_code_i;
    req_d.aux_value = aux_value_i;
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
    end
    if (req_adv) begin
      word_q   <= enc_word;
      status_q <= enc_status;
    end
  end

  // Encoder
  a64enc_core u_core (
    .req_i    (req_q),
    .word_o   (enc_word),
    .status_o (enc_status)
  );

  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;
  assign status_o    = status_q;

  // Error results never carry a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != a64enc_pkg::ST_OK) |-> (word_o == 32'd0))
    else $error("error result with nonzero word");

  // Backpressure only when both stages are full and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (req_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled without a full pipeline");

  // An accepted request is held in the request stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> req_valid_q)
    else $error("accepted request lost");

  // A taken result with nothing behind it leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !req_valid_q) |=> !out_valid_o)
    else $error("result repeated");

endmodule
